### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion shorthands for the rtl folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/scsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsp_pkg
// Shared types, constants and tables of the sorting classifier positioner
// ----------------------------------------------------------------------------
package scsp_pkg;

    localparam int QUARTER_STEPS = 50;

    localparam int DATA_W  = 10;
    localparam int STEP_W  = 7;
    localparam int WAIT_W  = 6;
    localparam int BASE_W  = 5;
    localparam int EXTRA_W = 4;
    localparam int INDEX_W = 8;

    localparam logic [STEP_W-1:0] STEPS_ONE = STEP_W'(QUARTER_STEPS);
    localparam logic [STEP_W-1:0] STEPS_TWO = STEP_W'(2 * QUARTER_STEPS);

    localparam logic [DATA_W-1:0] MIN_RESET = '1;

    // part classes, also the bin numbers
    localparam logic [1:0] CLASS_BLACK    = 2'd0;
    localparam logic [1:0] CLASS_ALUMINUM = 2'd1;
    localparam logic [1:0] CLASS_WHITE    = 2'd2;
    localparam logic [1:0] CLASS_STEEL    = 2'd3;

    // bin distance codes
    localparam logic [1:0] DIST_NONE = 2'd0;
    localparam logic [1:0] DIST_HALF = 2'd2;
    localparam logic [1:0] DIST_BACK = 2'd3;

    // item kinds
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_STEEL_THRESHOLD = 8'd0;
    localparam logic [INDEX_W-1:0] REG_WHITE_THRESHOLD = 8'd1;
    localparam logic [INDEX_W-1:0] REG_BLACK_THRESHOLD = 8'd2;
    localparam logic [INDEX_W-1:0] REG_BASE_STEP_DELAY = 8'd3;

    typedef struct packed {
        logic [STEP_W-1:0] idx;
        logic [STEP_W-1:0] total;
        logic              ccw;
    } step_plan_t;

    function automatic logic [WAIT_W-1:0] coil_of(input logic [1:0] phase);
        logic [WAIT_W-1:0] pat;
        case (phase)
            2'd0:    pat = 6'h36;
            2'd1:    pat = 6'h2E;
            2'd2:    pat = 6'h2D;
            default: pat = 6'h35;
        endcase
        return pat;
    endfunction

    function automatic logic [EXTRA_W-1:0] ramp_fwd(input logic [STEP_W-1:0] d);
        logic [EXTRA_W-1:0] e;
        case (d)
            7'd0:    e = 4'd14;
            7'd1:    e = 4'd13;
            7'd2:    e = 4'd12;
            7'd3:    e = 4'd11;
            7'd4:    e = 4'd9;
            7'd5:    e = 4'd7;
            7'd6:    e = 4'd4;
            default: e = 4'd0;
        endcase
        return e;
    endfunction

    function automatic logic [EXTRA_W-1:0] ramp_back(input logic [STEP_W-1:0] d);
        logic [EXTRA_W-1:0] e;
        case (d)
            7'd0:    e = 4'd14;
            7'd1:    e = 4'd13;
            7'd2:    e = 4'd12;
            7'd3:    e = 4'd11;
            7'd4:    e = 4'd9;
            7'd5:    e = 4'd7;
            7'd6:    e = 4'd5;
            7'd7:    e = 4'd3;
            7'd8:    e = 4'd1;
            default: e = 4'd0;
        endcase
        return e;
    endfunction

    function automatic logic [1:0] classify(
        input logic [DATA_W-1:0] value,
        input logic [DATA_W-1:0] steel_th,
        input logic [DATA_W-1:0] white_th,
        input logic [DATA_W-1:0] black_th
    );
        logic [1:0] cls;
        if (value < steel_th) begin
            cls = CLASS_ALUMINUM;
        end else if (value < white_th) begin
            cls = CLASS_STEEL;
        end else if (value < black_th) begin
            cls = CLASS_WHITE;
        end else begin
            cls = CLASS_BLACK;
        end
        return cls;
    endfunction

endpackage

### rtl/scsp_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsp_ramp
// Step wait time: base delay plus the symmetric accel/decel ramp extra
// ----------------------------------------------------------------------------
module scsp_ramp
    import scsp_pkg::*;
(
    input  step_plan_t        plan,
    input  logic [BASE_W-1:0] base_delay,
    output logic [WAIT_W-1:0] wait_ms
);

    logic [STEP_W-1:0]  from_end;
    logic [STEP_W-1:0]  ramp_pos;
    logic [EXTRA_W-1:0] extra;

    // distance to the nearer end of the move
    always_comb begin
        from_end = plan.total - plan.idx - STEP_W'(1);
        ramp_pos = plan.idx;
        if (plan.idx < plan.total && from_end < plan.idx) begin
            ramp_pos = from_end;
        end
        extra   = plan.ccw ? ramp_back(ramp_pos) : ramp_fwd(ramp_pos);
        wait_ms = WAIT_W'(base_delay) + WAIT_W'(extra);
    end

endmodule

### rtl/sort_classifier_stepper_positioner.sv
`timescale 1ns / 1ps
// output: a result is registered into the output register when its transaction is accepted
// throughput: one transaction per cycle while s_ready is high; the state update is a single pass of
//   compare, classify and ramp lookup between the state and output registers
// reset: aresetn synchronous active low; state and registers take their
//   default values, the output register empties
// ----------------------------------------------------------------------------
// sort_classifier_stepper_positioner
// Reflectance sorter that classifies parts and steps a four-bin rotary chute
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sort_classifier_stepper_positioner
    import scsp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]  cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [DATA_W-1:0]  s_sample,
    input  logic               s_window_open,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [WAIT_W-1:0]  m_coil_pattern,
    output logic               m_busy_res,
    output logic [1:0]         m_part_class,
    output logic               m_class_valid,
    output logic [1:0]         m_chute_bin,
    output logic               m_move_done,
    output logic [DATA_W-1:0]  m_min_reading
);

    logic [DATA_W-1:0] steel_th_reg, white_th_reg, black_th_reg;
    logic [BASE_W-1:0] base_delay_reg;

    logic [DATA_W-1:0] running_min_reg, running_min_next;
    logic [1:0]        bin_position_reg, bin_position_next;
    logic [1:0]        target_bin_reg, target_bin_next;
    logic [1:0]        phase_reg, phase_next;
    logic [STEP_W-1:0] step_count_reg, step_count_next;
    logic [STEP_W-1:0] step_total_reg, step_total_next;
    logic              turn_ccw_reg, turn_ccw_next;
    logic [WAIT_W-1:0] wait_ms_reg, wait_ms_next;
    logic              moving_reg, moving_next;
    logic [WAIT_W-1:0] coil_reg, coil_next;
    logic [1:0]        last_class_reg, last_class_next;

    logic              out_valid_reg;
    logic [WAIT_W-1:0] out_coil_reg;
    logic              out_busy_reg;
    logic [1:0]        out_class_reg;
    logic              out_class_valid_reg;
    logic [1:0]        out_bin_reg;
    logic              out_done_reg;
    logic [DATA_W-1:0] out_min_reg;

    logic              accept;
    logic              is_sample, closing, start;
    logic [DATA_W-1:0] min_upd;
    logic [1:0]        cls;
    logic [1:0]        bin_gap;
    logic [STEP_W-1:0] step_inc;
    logic [STEP_W-1:0] total_for_gap;
    step_plan_t        plan;
    logic [WAIT_W-1:0] ramp_wait;
    logic              cls_valid, done, step_go;
    logic [DATA_W-1:0] min_out;

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    // sample path and classification
    always_comb begin
        is_sample     = (s_mode == MODE_SAMPLE) && !moving_reg;
        closing       = is_sample && !s_window_open;
        min_upd       = (s_sample < running_min_reg) ? s_sample : running_min_reg;
        cls           = classify(min_upd, steel_th_reg, white_th_reg, black_th_reg);
        bin_gap       = cls - bin_position_reg;
        start         = closing && (bin_gap != DIST_NONE);
        total_for_gap = (bin_gap == DIST_HALF) ? STEPS_TWO : STEPS_ONE;
        step_inc      = step_count_reg + STEP_W'(1);
    end

    // step the ramp is looked up for: first step of a new move or next step
    always_comb begin
        plan.idx   = start ? '0 : step_inc;
        plan.total = start ? total_for_gap : step_total_reg;
        plan.ccw   = start ? (bin_gap == DIST_BACK) : turn_ccw_reg;
    end

    scsp_ramp u_ramp (
        .plan       (plan),
        .base_delay (base_delay_reg),
        .wait_ms    (ramp_wait)
    );

    always_comb begin
        running_min_next  = running_min_reg;
        bin_position_next = bin_position_reg;
        target_bin_next   = target_bin_reg;
        phase_next        = phase_reg;
        step_count_next   = step_count_reg;
        step_total_next   = step_total_reg;
        turn_ccw_next     = turn_ccw_reg;
        wait_ms_next      = wait_ms_reg;
        moving_next       = moving_reg;
        coil_next         = coil_reg;
        last_class_next   = last_class_reg;
        cls_valid         = 1'b0;
        done              = 1'b0;
        step_go           = 1'b0;
        min_out           = running_min_reg;

        if (is_sample) begin
            running_min_next = min_upd;
            min_out          = min_upd;
            if (closing) begin
                last_class_next  = cls;
                cls_valid        = 1'b1;
                running_min_next = MIN_RESET;
                if (start) begin
                    target_bin_next = cls;
                    turn_ccw_next   = (bin_gap == DIST_BACK);
                    step_total_next = total_for_gap;
                    step_count_next = '0;
                    moving_next     = 1'b1;
                    step_go         = 1'b1;
                end else begin
                    done = 1'b1;
                end
            end
        end else if (s_mode == MODE_TICK && moving_reg) begin
            if (wait_ms_reg > WAIT_W'(1)) begin
                wait_ms_next = wait_ms_reg - WAIT_W'(1);
            end else begin
                wait_ms_next    = '0;
                step_count_next = step_inc;
                if (step_inc >= step_total_reg) begin
                    moving_next       = 1'b0;
                    bin_position_next = target_bin_reg;
                    done              = 1'b1;
                end else begin
                    step_go = 1'b1;
                end
            end
        end

        if (step_go) begin
            phase_next   = turn_ccw_next ? phase_reg - 2'd1 : phase_reg + 2'd1;
            coil_next    = coil_of(phase_next);
            wait_ms_next = ramp_wait;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steel_th_reg   <= DATA_W'(300);
            white_th_reg   <= DATA_W'(800);
            black_th_reg   <= DATA_W'(860);
            base_delay_reg <= BASE_W'(6);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_STEEL_THRESHOLD: steel_th_reg   <= cfg_data;
                REG_WHITE_THRESHOLD: white_th_reg   <= cfg_data;
                REG_BLACK_THRESHOLD: black_th_reg   <= cfg_data;
                REG_BASE_STEP_DELAY: base_delay_reg <= cfg_data[BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_min_reg  <= MIN_RESET;
            bin_position_reg <= CLASS_BLACK;
            target_bin_reg   <= CLASS_BLACK;
            phase_reg        <= '0;
            step_count_reg   <= '0;
            step_total_reg   <= '0;
            turn_ccw_reg     <= 1'b0;
            wait_ms_reg      <= '0;
            moving_reg       <= 1'b0;
            coil_reg         <= '0;
            last_class_reg   <= CLASS_BLACK;
        end else if (accept) begin
            running_min_reg  <= running_min_next;
            bin_position_reg <= bin_position_next;
            target_bin_reg   <= target_bin_next;
            phase_reg        <= phase_next;
            step_count_reg   <= step_count_next;
            step_total_reg   <= step_total_next;
            turn_ccw_reg     <= turn_ccw_next;
            wait_ms_reg      <= wait_ms_next;
            moving_reg       <= moving_next;
            coil_reg         <= coil_next;
            last_class_reg   <= last_class_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_coil_reg        <= coil_next;
            out_busy_reg        <= moving_next;
            out_class_reg       <= last_class_next;
            out_class_valid_reg <= cls_valid;
            out_bin_reg         <= bin_position_next;
            out_done_reg        <= done;
            out_min_reg         <= min_out;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_coil_pattern = out_coil_reg;
    assign m_busy_res     = out_busy_reg;
    assign m_part_class   = out_class_reg;
    assign m_class_valid  = out_class_valid_reg;
    assign m_chute_bin    = out_bin_reg;
    assign m_move_done    = out_done_reg;
    assign m_min_reading  = out_min_reg;

    // a finished move never reports busy
    `ASSERT_IMPLIES(a_done_not_busy, aclk, aresetn, out_valid_reg && out_done_reg, !out_busy_reg)
    // a running move always has steps left
    `ASSERT_IMPLIES(a_steps_left, aclk, aresetn, moving_reg, step_count_reg < step_total_reg)
    // at rest the chute sits on its last target
    `ASSERT_IMPLIES(a_rest_on_target, aclk, aresetn, !moving_reg, bin_position_reg == target_bin_reg)
    // the move only starts from a classifying transaction
    `ASSERT_NEXT(a_start_classifies, aclk, aresetn, accept && start, out_class_valid_reg && moving_reg)

endmodule

### verif/sort_classifier_stepper_positioner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_classifier_stepper_positioner_tb
// Self-checking bench for the reflectance sorter and rotary chute stepper.
// A directed table hits reset values, threshold edges, each move direction,
// dropped samples and parts that land in the current bin. Random phases then
// send parts and millisecond ticks under several register settings and
// handshake stall patterns. Every result is checked against a cycle-free
// model of the classifier and the ramped stepper kept inside the bench.
// ----------------------------------------------------------------------------
module sort_classifier_stepper_positioner_tb;
    import scsp_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam logic [INDEX_W-1:0] REG_UNUSED = 8'hFF;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum logic [1:0] {
        ROW_PREDICTED, ROW_TYPED, ROW_UNTIL_PARKED, ROW_FAST_STEPS
    } row_kind_t;

    typedef struct packed {
        logic [5:0]        coil_pattern;
        logic              busy_res;
        logic [1:0]        part_class;
        logic              class_valid;
        logic [1:0]        chute_bin;
        logic              move_done;
        logic [DATA_W-1:0] min_reading;
    } sorter_out_t;

    typedef struct {
        logic              mode;
        logic [DATA_W-1:0] sample;
        logic              win;
        row_kind_t         kind;
        sorter_out_t       res;
    } stim_row_t;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]  cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_mode = 1'b0;
    logic [DATA_W-1:0]  s_sample = '0;
    logic               s_window_open = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [WAIT_W-1:0]  m_coil_pattern;
    logic               m_busy_res;
    logic [1:0]         m_part_class;
    logic               m_class_valid;
    logic [1:0]         m_chute_bin;
    logic               m_move_done;
    logic [DATA_W-1:0]  m_min_reading;

    sort_classifier_stepper_positioner uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_sample      (s_sample),
        .s_window_open (s_window_open),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coil_pattern(m_coil_pattern),
        .m_busy_res    (m_busy_res),
        .m_part_class  (m_part_class),
        .m_class_valid (m_class_valid),
        .m_chute_bin   (m_chute_bin),
        .m_move_done   (m_move_done),
        .m_min_reading (m_min_reading)
    );

    // bench copy of the sorter registers and stepper state
    logic [DATA_W-1:0] thr_steel = 10'd300;
    logic [DATA_W-1:0] thr_white = 10'd800;
    logic [DATA_W-1:0] thr_black = 10'd860;
    logic [4:0]        step_base_ms = 5'd6;
    logic [DATA_W-1:0] trk_min = '1;
    logic [1:0]        bin_at = CLASS_BLACK;
    logic [1:0]        bin_goal = CLASS_BLACK;
    logic [1:0]        coil_phase = 2'd0;
    logic [6:0]        steps_done = '0;
    logic [6:0]        steps_planned = '0;
    logic              dir_ccw = 1'b0;
    logic [5:0]        ms_left = '0;
    logic              in_motion = 1'b0;
    logic [5:0]        coil_drive = '0;
    logic [1:0]        class_last = CLASS_BLACK;

    sorter_out_t expected_q[$];
    int          errors = 0;
    idle_mode_t  idle_mode = IDLE_NONE;
    logic        hold_off = 1'b0;
    event        stall_burst;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // extra ms of a step, symmetric about the middle of the move
    function automatic logic [3:0] ramp_ms(input logic [6:0] idx);
        int d;
        int i;
        int tot;
        i = idx;
        tot = steps_planned;
        d = i;
        if (i < tot && tot - 1 - i < d) d = tot - 1 - i;
        if (dir_ccw) begin
            case (d)
                0: return 4'd14;
                1: return 4'd13;
                2: return 4'd12;
                3: return 4'd11;
                4: return 4'd9;
                5: return 4'd7;
                6: return 4'd5;
                7: return 4'd3;
                8: return 4'd1;
                default: return 4'd0;
            endcase
        end
        case (d)
            0: return 4'd14;
            1: return 4'd13;
            2: return 4'd12;
            3: return 4'd11;
            4: return 4'd9;
            5: return 4'd7;
            6: return 4'd4;
            default: return 4'd0;
        endcase
    endfunction

    function automatic void advance_coil();
        coil_phase = dir_ccw ? coil_phase - 2'd1 : coil_phase + 2'd1;
        case (coil_phase)
            2'd0: coil_drive = 6'h36;
            2'd1: coil_drive = 6'h2E;
            2'd2: coil_drive = 6'h2D;
            default: coil_drive = 6'h35;
        endcase
        ms_left = 6'(step_base_ms) + 6'(ramp_ms(steps_done));
    endfunction

    task automatic predict_sorter(input logic mode, input logic [DATA_W-1:0] smp,
                                  input logic win, output sorter_out_t r);
        logic [1:0] cls;
        logic [1:0] bin_gap;
        r = '0;
        r.min_reading = trk_min;
        if (mode == MODE_SAMPLE) begin
            if (!in_motion) begin
                if (smp < trk_min) trk_min = smp;
                r.min_reading = trk_min;
                if (!win) begin
                    if (trk_min < thr_steel) cls = CLASS_ALUMINUM;
                    else if (trk_min < thr_white) cls = CLASS_STEEL;
                    else if (trk_min < thr_black) cls = CLASS_WHITE;
                    else cls = CLASS_BLACK;
                    class_last = cls;
                    r.class_valid = 1'b1;
                    trk_min = '1;
                    bin_gap = cls - bin_at;
                    if (bin_gap == DIST_NONE) begin
                        r.move_done = 1'b1;
                    end else begin
                        bin_goal = cls;
                        dir_ccw = (bin_gap == DIST_BACK);
                        steps_planned = (bin_gap == DIST_HALF) ? STEPS_TWO : STEPS_ONE;
                        steps_done = '0;
                        in_motion = 1'b1;
                        advance_coil();
                    end
                end
            end
        end else if (in_motion) begin
            if (ms_left > 6'd1) begin
                ms_left = ms_left - 6'd1;
            end else begin
                ms_left = '0;
                steps_done = steps_done + 7'd1;
                if (steps_done >= steps_planned) begin
                    in_motion = 1'b0;
                    bin_at = bin_goal;
                    r.move_done = 1'b1;
                end else begin
                    advance_coil();
                end
            end
        end
        r.coil_pattern = coil_drive;
        r.busy_res = in_motion;
        r.part_class = class_last;
        r.chute_bin = bin_at;
    endtask

    function automatic bit send_gap();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(99) < 87;
            IDLE_BOTH: return $urandom_range(99) < 25;
            default:   return 1'b0;
        endcase
    endfunction

    task automatic send_item(input logic mode, input logic [DATA_W-1:0] smp, input logic win,
                             input bit use_typed, input sorter_out_t typed_res);
        sorter_out_t want;
        if (send_gap()) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (send_gap());
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_sample      <= smp;
        s_window_open <= win;
        do @(posedge aclk); while (!s_ready);
        predict_sorter(mode, smp, win, want);
        expected_q.push_back(use_typed ? typed_res : want);
    endtask

    task automatic cfg_beat(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_STEEL_THRESHOLD: thr_steel = val;
            REG_WHITE_THRESHOLD: thr_white = val;
            REG_BLACK_THRESHOLD: thr_black = val;
            REG_BASE_STEP_DELAY: step_base_ms = val[4:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [DATA_W-1:0] steel, input logic [DATA_W-1:0] white,
                               input logic [DATA_W-1:0] black, input logic [DATA_W-1:0] base,
                               input bit stray);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        if (stray) cfg_beat(REG_UNUSED, 10'h3FF);
        cfg_beat(REG_STEEL_THRESHOLD, steel);
        cfg_beat(REG_WHITE_THRESHOLD, white);
        cfg_beat(REG_BLACK_THRESHOLD, black);
        cfg_beat(REG_BASE_STEP_DELAY, base);
        cfg_valid <= 1'b0;
    endtask

    // readings cluster around the thresholds half of the time
    function automatic logic [DATA_W-1:0] pick_reading();
        int v;
        case ($urandom_range(5))
            0: v = int'(thr_steel);
            1: v = int'(thr_white);
            2: v = int'(thr_black);
            default: return DATA_W'($urandom_range(1023));
        endcase
        v = v + int'($urandom_range(4)) - 2;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return DATA_W'(v);
    endfunction

    task automatic run_phase(input int target, input idle_mode_t im, input bit squeeze);
        int counted;
        counted = 0;
        idle_mode = im;
        if (squeeze) -> stall_burst;
        while (counted < target) begin
            if (in_motion) begin
                if ($urandom_range(9) == 0) begin
                    // dropped while the chute turns
                    send_item(MODE_SAMPLE, pick_reading(), 1'($urandom_range(1)), 1'b0, '0);
                end else begin
                    send_item(MODE_TICK, DATA_W'($urandom_range(1023)), 1'($urandom_range(1)),
                              1'b0, '0);
                    counted++;
                end
            end else if ($urandom_range(9) == 0) begin
                send_item(MODE_TICK, DATA_W'($urandom_range(1023)), 1'($urandom_range(1)),
                          1'b0, '0);
            end else begin
                send_item(MODE_SAMPLE, pick_reading(), $urandom_range(3) != 0, 1'b0, '0);
                counted++;
            end
        end
        s_valid <= 1'b0;
    endtask

    task automatic add_row(input logic mode, input logic [DATA_W-1:0] smp, input logic win,
                           input row_kind_t kind, input sorter_out_t res,
                           ref stim_row_t rows[$]);
        stim_row_t row;
        row.mode = mode;
        row.sample = smp;
        row.win = win;
        row.kind = kind;
        row.res = res;
        rows.push_back(row);
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            errors++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // receive side: check each transaction, then pick ready for the next cycle
    always @(posedge aclk) begin : result_check
        sorter_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                errors++;
                $error("result transaction with no item outstanding");
            end else begin
                want = expected_q.pop_front();
                check_field("coil_pattern", want.coil_pattern, m_coil_pattern);
                check_field("busy_res", want.busy_res, m_busy_res);
                check_field("part_class", want.part_class, m_part_class);
                check_field("class_valid", want.class_valid, m_class_valid);
                check_field("chute_bin", want.chute_bin, m_chute_bin);
                check_field("move_done", want.move_done, m_move_done);
                check_field("min_reading", want.min_reading, m_min_reading);
            end
        end
        case (idle_mode)
            IDLE_RECV: m_ready <= !hold_off && ($urandom_range(99) >= 87);
            IDLE_BOTH: m_ready <= !hold_off && ($urandom_range(99) >= 25);
            default:   m_ready <= !hold_off;
        endcase
    end

    // long receiver hold-off so the output register fills and input backs up
    initial begin
        forever begin
            @(stall_burst);
            hold_off <= 1'b1;
            repeat (300) @(posedge aclk);
            hold_off <= 1'b0;
        end
    end

    initial begin : watchdog
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        stim_row_t rows[$];
        stim_row_t row;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset, window min tracking, first move and a dropped close
        add_row(MODE_TICK, 10'd0, 1'b0, ROW_TYPED,
                '{6'h00, 1'b0, CLASS_BLACK, 1'b0, CLASS_BLACK, 1'b0, 10'd1023}, rows);
        add_row(MODE_SAMPLE, 10'd1023, 1'b1, ROW_TYPED,
                '{6'h00, 1'b0, CLASS_BLACK, 1'b0, CLASS_BLACK, 1'b0, 10'd1023}, rows);
        add_row(MODE_SAMPLE, 10'd0, 1'b1, ROW_TYPED,
                '{6'h00, 1'b0, CLASS_BLACK, 1'b0, CLASS_BLACK, 1'b0, 10'd0}, rows);
        add_row(MODE_SAMPLE, 10'd1023, 1'b0, ROW_TYPED,
                '{6'h2E, 1'b1, CLASS_ALUMINUM, 1'b1, CLASS_BLACK, 1'b0, 10'd0}, rows);
        add_row(MODE_SAMPLE, 10'd7, 1'b0, ROW_TYPED,
                '{6'h2E, 1'b1, CLASS_ALUMINUM, 1'b0, CLASS_BLACK, 1'b0, 10'd1023}, rows);
        // first steps at the reset step delay, then short steps for the rest
        repeat (24) add_row(MODE_TICK, 10'd0, 1'b0, ROW_PREDICTED, '0, rows);
        add_row(MODE_TICK, 10'd0, 1'b0, ROW_FAST_STEPS, '0, rows);
        add_row(MODE_TICK, 10'd0, 1'b0, ROW_UNTIL_PARKED, '0, rows);
        // threshold edges, each direction of travel, parts already in place
        add_row(MODE_SAMPLE, 10'd900, 1'b1, ROW_PREDICTED, '0, rows);
        add_row(MODE_SAMPLE, 10'd299, 1'b0, ROW_PREDICTED, '0, rows);
        add_row(MODE_SAMPLE, 10'd300, 1'b0, ROW_PREDICTED, '0, rows);
        add_row(MODE_TICK, 10'h3FF, 1'b1, ROW_UNTIL_PARKED, '0, rows);
        add_row(MODE_SAMPLE, 10'd799, 1'b0, ROW_PREDICTED, '0, rows);
        add_row(MODE_SAMPLE, 10'd800, 1'b0, ROW_PREDICTED, '0, rows);
        add_row(MODE_TICK, 10'd0, 1'b0, ROW_UNTIL_PARKED, '0, rows);
        add_row(MODE_SAMPLE, 10'd859, 1'b0, ROW_PREDICTED, '0, rows);
        add_row(MODE_SAMPLE, 10'd860, 1'b0, ROW_PREDICTED, '0, rows);
        add_row(MODE_TICK, 10'd0, 1'b0, ROW_UNTIL_PARKED, '0, rows);
        add_row(MODE_SAMPLE, 10'd1023, 1'b0, ROW_PREDICTED, '0, rows);

        foreach (rows[i]) begin
            row = rows[i];
            if (row.kind == ROW_FAST_STEPS) begin
                s_valid <= 1'b0;
                load_config(10'd300, 10'd800, 10'd860, 10'd1, 1'b0);
            end else if (row.kind == ROW_UNTIL_PARKED) begin
                while (in_motion) send_item(row.mode, row.sample, row.win, 1'b0, '0);
            end else begin
                send_item(row.mode, row.sample, row.win, row.kind == ROW_TYPED, row.res);
            end
        end
        s_valid <= 1'b0;

        load_config(10'd250, 10'd700, 10'd900, 10'd1, 1'b0);
        run_phase(50, IDLE_NONE, 1'b0);
        // zero step delay, upper data bits set on the 5-bit register
        load_config(10'd1023, 10'd1023, 10'd1023, {5'h15, 5'd0}, 1'b1);
        run_phase(40, IDLE_SEND, 1'b0);
        load_config(10'd0, 10'd0, 10'd0, 10'd31, 1'b0);
        run_phase(40, IDLE_RECV, 1'b0);
        load_config(DATA_W'($urandom_range(100, 400)), DATA_W'($urandom_range(450, 800)),
                    DATA_W'($urandom_range(801, 1000)), 10'd2, 1'b1);
        run_phase(50, IDLE_BOTH, 1'b0);
        load_config(10'd300, 10'd800, 10'd860, 10'd1, 1'b0);
        run_phase(60, IDLE_NONE, 1'b1);

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
